/* rtl/assert_macros.svh */
// Assertion macros shared by the staff line run thicken RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define SLRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define SLRT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/slrt_pkg.sv */
// Shared constants, types and helpers for the staff line run thicken block.
`timescale 1ns / 1ps

package slrt_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int COORD_W    = $clog2(MAX_DIM + 1);
  localparam int CFG_W      = 10;
  localparam int CALC_W     = (COORD_W > CFG_W) ? COORD_W : CFG_W;
  localparam int PIX_W      = 8;
  localparam int IDX_W      = 2;

  localparam logic [IDX_W-1:0] REG_RUN_LIMIT    = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [CFG_W-1:0] RUN_LIMIT_RST    = 10'd3;
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 10'd512;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 10'd512;

  localparam logic [PIX_W-1:0] PIX_LINE     = 8'd0;
  localparam logic [PIX_W-1:0] PIX_OFF_LINE = 8'd255;

  // Border skipped on each side, and the row limit of the run walk.
  localparam int BORDER   = 2;
  localparam int RUN_EDGE = 3;
  localparam int MIN_DIM  = 2 * BORDER + 1;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  mask;
    logic              black;
  } load_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] mask_addr;
    logic [ADDR_W-1:0] black_addr;
  } seq_rd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } res_wr_t;

  typedef struct packed {
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [CNT_W-1:0]   total;
    logic [CFG_W-1:0]   run_limit;
  } job_t;

  function automatic logic [COORD_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input int unsigned lim);
    logic [CALC_W-1:0]  x;
    logic [COORD_W-1:0] r;
    x = CALC_W'(v);
    if (x == '0) begin
      r = COORD_W'(1);
    end else if (x > CALC_W'(lim)) begin
      r = COORD_W'(lim);
    end else begin
      r = COORD_W'(x);
    end
    return r;
  endfunction

endpackage

/* rtl/slrt_store.sv */
// Mask, black flag and result image stores.
`timescale 1ns / 1ps

module slrt_store (
  input  logic                           clk,
  input  slrt_pkg::load_wr_t             load_wr,
  input  slrt_pkg::seq_rd_t              seq_rd,
  input  slrt_pkg::res_wr_t              res_wr,
  input  logic                           res_re,
  input  logic [slrt_pkg::ADDR_W-1:0]    res_raddr,
  output logic [slrt_pkg::PIX_W-1:0]     mask_q,
  output logic                           black_q,
  output logic [slrt_pkg::PIX_W-1:0]     res_q
);

  logic [slrt_pkg::PIX_W-1:0] mask_mem  [slrt_pkg::DEPTH];
  logic                       black_mem [slrt_pkg::DEPTH];
  logic [slrt_pkg::PIX_W-1:0] res_mem   [slrt_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (load_wr.en) begin
      mask_mem[load_wr.addr] <= load_wr.mask;
    end
    mask_q <= mask_mem[seq_rd.mask_addr];
  end

  always_ff @(posedge clk) begin
    if (load_wr.en) begin
      black_mem[load_wr.addr] <= load_wr.black;
    end
    black_q <= black_mem[seq_rd.black_addr];
  end

  always_ff @(posedge clk) begin
    if (res_wr.en) begin
      res_mem[res_wr.addr] <= res_wr.data;
    end
    if (res_re) begin
      res_q <= res_mem[res_raddr];
    end
  end

endmodule

/* rtl/slrt_seq.sv */
// Frame sequencer: mask copy, vertical run walk and result update.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slrt_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  slrt_pkg::job_t              job,
  input  logic [slrt_pkg::PIX_W-1:0]  mask_q,
  input  logic                        black_q,
  output slrt_pkg::seq_rd_t           seq_rd,
  output slrt_pkg::res_wr_t           res_wr,
  output logic                        busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_COPY,
    S_COPY_END,
    S_P_REQ,
    S_P_CHK,
    S_UP_REQ,
    S_UP_CHK,
    S_DN_REQ,
    S_DN_CHK,
    S_DECIDE,
    S_CLR_REQ,
    S_CLR_CHK,
    S_NEXT
  } state_t;

  state_t                          state;
  logic [slrt_pkg::ADDR_W-1:0]     cnt;
  logic [slrt_pkg::ADDR_W-1:0]     copy_a;
  logic                            copy_v;
  logic [slrt_pkg::COORD_W-1:0]    i;
  logic [slrt_pkg::COORD_W-1:0]    j;
  logic [slrt_pkg::COORD_W-1:0]    k;
  logic [slrt_pkg::COORD_W-1:0]    l;
  logic [slrt_pkg::ADDR_W-1:0]     pix;
  logic [slrt_pkg::ADDR_W-1:0]     kaddr;
  logic [slrt_pkg::ADDR_W-1:0]     laddr;

  logic [slrt_pkg::ADDR_W-1:0]     wa;
  logic [slrt_pkg::ADDR_W-1:0]     opa;
  logic [slrt_pkg::ADDR_W-1:0]     sum;
  logic                            up;
  logic                            dn;
  logic [slrt_pkg::COORD_W-1:0]    wm3;
  logic [slrt_pkg::COORD_W-1:0]    hm3;
  logic                            small_frame;
  logic                            fits;

  assign busy = (state != S_IDLE);
  assign wa   = slrt_pkg::ADDR_W'(job.w);
  assign wm3  = job.w - slrt_pkg::COORD_W'(slrt_pkg::RUN_EDGE);
  assign hm3  = job.h - slrt_pkg::COORD_W'(slrt_pkg::RUN_EDGE);
  assign small_frame = (job.w < slrt_pkg::COORD_W'(slrt_pkg::MIN_DIM)) ||
                       (job.h < slrt_pkg::COORD_W'(slrt_pkg::MIN_DIM));
  assign fits = slrt_pkg::CALC_W'(l - k) <= slrt_pkg::CALC_W'(job.run_limit);

  // Shared row-step adder.
  assign up  = (state == S_UP_REQ) || (state == S_UP_CHK);
  assign dn  = (state == S_DN_REQ) || (state == S_DN_CHK);
  assign opa = dn ? laddr : kaddr;
  assign sum = up ? (opa - wa) : (opa + wa);

  always_comb begin
    case (state)
      S_COPY:  seq_rd.mask_addr = cnt;
      S_P_REQ: seq_rd.mask_addr = pix;
      default: seq_rd.mask_addr = kaddr;
    endcase
    seq_rd.black_addr = sum;
  end

  always_comb begin
    res_wr.en   = 1'b0;
    res_wr.addr = copy_a;
    res_wr.data = mask_q;
    if (copy_v) begin
      res_wr.en = 1'b1;
    end else if (state == S_DECIDE && !fits) begin
      res_wr.en   = 1'b1;
      res_wr.addr = pix;
      res_wr.data = slrt_pkg::PIX_OFF_LINE;
    end else if (state == S_CLR_CHK && mask_q != slrt_pkg::PIX_LINE) begin
      res_wr.en   = 1'b1;
      res_wr.addr = kaddr;
      res_wr.data = slrt_pkg::PIX_LINE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      copy_v <= 1'b0;
    end else begin
      copy_v <= (state == S_COPY);
      copy_a <= cnt;
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (start) begin
            state <= S_COPY;
          end
        end
        S_COPY: begin
          cnt <= cnt + 1'b1;
          if (slrt_pkg::CNT_W'(cnt) == job.total - slrt_pkg::CNT_W'(1)) begin
            state <= S_COPY_END;
          end
        end
        S_COPY_END: begin
          i   <= slrt_pkg::COORD_W'(slrt_pkg::BORDER);
          j   <= slrt_pkg::COORD_W'(slrt_pkg::BORDER);
          pix <= (wa << 1) + slrt_pkg::ADDR_W'(slrt_pkg::BORDER);
          state <= small_frame ? S_IDLE : S_P_REQ;
        end
        S_P_REQ: begin
          state <= S_P_CHK;
        end
        S_P_CHK: begin
          k     <= i;
          l     <= i;
          kaddr <= pix;
          laddr <= pix;
          state <= (mask_q == slrt_pkg::PIX_LINE) ? S_UP_REQ : S_NEXT;
        end
        S_UP_REQ: begin
          state <= (k > slrt_pkg::COORD_W'(slrt_pkg::RUN_EDGE)) ? S_UP_CHK : S_DN_REQ;
        end
        S_UP_CHK: begin
          if (black_q) begin
            k     <= k - 1'b1;
            kaddr <= sum;
            state <= S_UP_REQ;
          end else begin
            state <= S_DN_REQ;
          end
        end
        S_DN_REQ: begin
          state <= (l < hm3) ? S_DN_CHK : S_DECIDE;
        end
        S_DN_CHK: begin
          if (black_q) begin
            l     <= l + 1'b1;
            laddr <= sum;
            state <= S_DN_REQ;
          end else begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= fits ? S_CLR_REQ : S_NEXT;
        end
        S_CLR_REQ: begin
          state <= S_CLR_CHK;
        end
        S_CLR_CHK: begin
          if (k == l) begin
            state <= S_NEXT;
          end else begin
            k     <= k + 1'b1;
            kaddr <= sum;
            state <= S_CLR_REQ;
          end
        end
        S_NEXT: begin
          if (j == wm3) begin
            j <= slrt_pkg::COORD_W'(slrt_pkg::BORDER);
            if (i == hm3) begin
              state <= S_IDLE;
            end else begin
              i     <= i + 1'b1;
              pix   <= pix + slrt_pkg::ADDR_W'(slrt_pkg::MIN_DIM);
              state <= S_P_REQ;
            end
          end else begin
            j     <= j + 1'b1;
            pix   <= pix + 1'b1;
            state <= S_P_REQ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SLRT_ASSERT(a_up_floor, (state == S_UP_CHK) |-> (k > slrt_pkg::COORD_W'(slrt_pkg::RUN_EDGE)), "run walk passed the top row limit")
  `SLRT_ASSERT(a_clr_order, (state == S_CLR_REQ || state == S_CLR_CHK) |-> (k <= l), "clear walk passed the run bottom")
  `SLRT_ASSERT_RST(a_rst_idle, rst |=> (state == S_IDLE), "sequencer not idle after reset")

endmodule

/* rtl/staff_line_run_thicken.sv */
// Top level of the staff line run thicken block: stream ports, pointers, config.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
// Loads a line mask and a black flag image in raster order, cleans the mask
// along short vertical black runs, and streams the result back out.
// Slave beat: s_tuser selects the command (0 load, 1 read). A load beat
// carries the mask pixel and black flag and yields no output. A read beat
// yields one master beat with the result pixel; m_tlast marks the frame end.
// Config: cfg_index 0 run limit, 1 image width, 2 image height; cfg_ready
// drops while a frame is processing.
// A read beat sets rd_pend as the result store is read, then m_tvalid
// rises; no read is taken while one is pending. The load of the last frame
// pixel starts processing, during which s_tready stays low: the mask is
// copied, then each interior pixel is checked; at a line pixel the black
// run is walked up and down and judged against the run limit, and the rows
// of a short run are cleared. Frames under 5 by 5 stop after the copy.
// Each store has one read port and one adder steps the rows.
// Reset clears the pointers, the sequencer and the output beat and restores
// the register defaults; image contents are undefined until a frame loads.
// A stalled master side holds its beat and blocks further slave beats.

module staff_line_run_thicken (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // mask_pixel, bin_black
  input  logic                          s_tuser,   // cmd
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [slrt_pkg::PIX_W-1:0]    m_tdata,   // out_pixel
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [slrt_pkg::IDX_W-1:0]    cfg_index,
  input  logic [slrt_pkg::CFG_W-1:0]    cfg_data
);

  logic [slrt_pkg::CFG_W-1:0]     run_limit;
  logic [slrt_pkg::CFG_W-1:0]     image_width;
  logic [slrt_pkg::CFG_W-1:0]     image_height;
  logic [slrt_pkg::ADDR_W-1:0]    lp;
  logic [slrt_pkg::ADDR_W-1:0]    rp;
  logic                           rd_pend;
  logic                           rd_last;

  slrt_pkg::job_t                 job;
  slrt_pkg::load_wr_t             load_wr;
  slrt_pkg::seq_rd_t              seq_rd;
  slrt_pkg::res_wr_t              res_wr;
  logic [slrt_pkg::PIX_W-1:0]     mask_q;
  logic                           black_q;
  logic [slrt_pkg::PIX_W-1:0]     res_q;
  logic                           busy;

  logic                           accept;
  logic                           is_load;
  logic                           is_read;
  logic [slrt_pkg::ADDR_W-1:0]    lp_use;
  logic [slrt_pkg::ADDR_W-1:0]    rp_use;
  logic [slrt_pkg::CNT_W-1:0]     lp_inc;
  logic                           frame_end;
  logic                           last;
  logic                           start;

  assign cfg_ready = !busy;

  assign job.w         = slrt_pkg::clamp_dim(image_width, slrt_pkg::MAX_WIDTH);
  assign job.h         = slrt_pkg::clamp_dim(image_height, slrt_pkg::MAX_HEIGHT);
  assign job.total     = slrt_pkg::CNT_W'(job.w) * slrt_pkg::CNT_W'(job.h);
  assign job.run_limit = run_limit;

  assign s_tready = !busy && !rd_pend && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign is_load  = accept && !s_tuser;
  assign is_read  = accept && s_tuser;

  assign lp_use    = (slrt_pkg::CNT_W'(lp) >= job.total) ? '0 : lp;
  assign rp_use    = (slrt_pkg::CNT_W'(rp) >= job.total) ? '0 : rp;
  assign lp_inc    = slrt_pkg::CNT_W'(lp_use) + 1'b1;
  assign frame_end = (lp_inc >= job.total);
  assign last      = (slrt_pkg::CNT_W'(rp_use) == job.total - slrt_pkg::CNT_W'(1));
  assign start     = is_load && frame_end;

  assign load_wr.en    = is_load;
  assign load_wr.addr  = lp_use;
  assign load_wr.mask  = s_tdata[slrt_pkg::PIX_W-1:0];
  assign load_wr.black = s_tdata[slrt_pkg::PIX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      run_limit    <= slrt_pkg::RUN_LIMIT_RST;
      image_width  <= slrt_pkg::IMAGE_WIDTH_RST;
      image_height <= slrt_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        slrt_pkg::REG_RUN_LIMIT:    run_limit    <= cfg_data;
        slrt_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        slrt_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lp       <= '0;
      rp       <= '0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_pend <= is_read;
      if (is_load) begin
        if (frame_end) begin
          lp <= '0;
          rp <= '0;
        end else begin
          lp <= lp_inc[slrt_pkg::ADDR_W-1:0];
        end
      end
      if (is_read) begin
        rd_last <= last;
        rp      <= last ? '0 : rp_use + 1'b1;
      end
      if (rd_pend) begin
        m_tvalid <= 1'b1;
        m_tdata  <= res_q;
        m_tlast  <= rd_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  slrt_store u_store (
    .clk       (clk),
    .load_wr   (load_wr),
    .seq_rd    (seq_rd),
    .res_wr    (res_wr),
    .res_re    (is_read),
    .res_raddr (rp_use),
    .mask_q    (mask_q),
    .black_q   (black_q),
    .res_q     (res_q)
  );

  slrt_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .job     (job),
    .mask_q  (mask_q),
    .black_q (black_q),
    .seq_rd  (seq_rd),
    .res_wr  (res_wr),
    .busy    (busy)
  );

  `SLRT_ASSERT(a_busy_block, busy |-> !s_tready, "beat taken while frame processing")
  `SLRT_ASSERT(a_pend_show, rd_pend |=> m_tvalid, "read beat lost before output")
  `SLRT_ASSERT_RST(a_rst_out, rst |=> !m_tvalid, "output beat valid after reset")

endmodule
